// File: hw/rtl/rpct_pkg.sv
// ----------------------------------------------------------------------------
// rpct_pkg
// Shared sizes, status codes, register indexes and helper types for the
// rectangle placement and collision table.
// ----------------------------------------------------------------------------
package rpct_pkg;

   localparam int MAX_RECTS = 64;
   localparam int IDX_W     = $clog2(MAX_RECTS);
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);
   localparam int CSR_IDX_W = 3;

   localparam logic [3:0] ST_STORED   = 4'd0;
   localparam logic [3:0] ST_NARROW   = 4'd1;
   localparam logic [3:0] ST_SHORT    = 4'd2;
   localparam logic [3:0] ST_XOUT     = 4'd3;
   localparam logic [3:0] ST_YOUT     = 4'd4;
   localparam logic [3:0] ST_COLLIDE  = 4'd5;
   localparam logic [3:0] ST_FULL     = 4'd6;
   localparam logic [3:0] ST_FOUND    = 4'd7;
   localparam logic [3:0] ST_NOTFOUND = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_COLS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_ROWS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATED    = 3'd4;

   localparam logic [7:0] RST_MIN_WIDTH  = 8'd3;
   localparam logic [7:0] RST_MIN_HEIGHT = 8'd3;
   localparam logic [7:0] RST_FIELD_COLS = 8'd80;
   localparam logic [7:0] RST_FIELD_ROWS = 8'd25;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic start;
      logic scan;
      logic commit;
   } rpct_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic slot_free;
   } rpct_stat_type;

   // strict overlap of the inclusive spans [lo0, lo0+len0-1] and [lo1, lo1+len1-1]
   // a zero length span runs backwards by one cell, so take min and max of the ends
   function automatic logic spans_overlap(input logic [7:0] lo0, input logic [7:0] len0,
                                          input logic [7:0] lo1, input logic [7:0] len1);
      logic signed [9:0] a0, a1, b0, b1;
      logic signed [9:0] amax, amin, bmax, bmin;
      a0   = $signed({2'b00, lo0});
      a1   = $signed({2'b00, lo0}) + $signed({2'b00, len0}) - 10'sd1;
      b0   = $signed({2'b00, lo1});
      b1   = $signed({2'b00, lo1}) + $signed({2'b00, len1}) - 10'sd1;
      amax = (a0 > a1) ? a0 : a1;
      amin = (a0 < a1) ? a0 : a1;
      bmax = (b0 > b1) ? b0 : b1;
      bmin = (b0 < b1) ? b0 : b1;
      return (amax > bmin) && (amin < bmax);
   endfunction

endpackage

// File: hw/rtl/rpct_ifs.sv
// ----------------------------------------------------------------------------
// rpct channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface rpct_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] corner_x;
   logic [7:0] corner_y;
   logic [7:0] rect_width;
   logic [7:0] rect_height;

   modport source (output valid, func, corner_x, corner_y, rect_width, rect_height,
                   input ready);
   modport sink   (input valid, func, corner_x, corner_y, rect_width, rect_height,
                   output ready);
endinterface

interface rpct_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [5:0] entry_index;

   modport source (output valid, status, entry_index, input ready);
   modport sink   (input valid, status, entry_index, output ready);
endinterface

interface rpct_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rect_placement_collision_table.sv
// ----------------------------------------------------------------------------
// rect_placement_collision_table
// Table of placed rectangles with insert-with-collision-test and find by corner.
// ----------------------------------------------------------------------------
// req_bus carries one request: func 0 inserts a rectangle, func 1 looks up a
// stored rectangle by its lower left corner. Each request gives one response
// on rsp_bus with a status code and an entry index. csr_bus writes the
// minimum size, field size and rotation registers; it is always ready.
// Requests are taken one at a time. An insert that fails a size or field
// check, any request on an empty table, or an insert into a full table goes
// from its checks straight to the response. Otherwise the table is walked one
// entry per cycle through the memory's single read port, ending early at the
// first collision or corner match.
// A finished response sits in the output register; while the receiver
// stalls the next request is still accepted and worked, and it waits only
// to post its own response. Reset empties the table and loads the register
// defaults; no clearing pass is needed, as only written entries are read.
// ----------------------------------------------------------------------------
module rect_placement_collision_table
   import rpct_pkg::*;
(
   input logic      clock,
   input logic      reset,
   rpct_req_if.sink req_bus,
   rpct_rsp_if.source rsp_bus,
   rpct_csr_if.sink csr_bus
);

   rpct_cmd_type  cmd;
   rpct_stat_type stat;

   rpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpct_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_bus.func),
      .req_corner_x    (req_bus.corner_x),
      .req_corner_y    (req_bus.corner_y),
      .req_rect_width  (req_bus.rect_width),
      .req_rect_height (req_bus.rect_height),
      .csr_valid       (csr_bus.valid),
      .csr_ready       (csr_bus.ready),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_status      (rsp_bus.status),
      .rsp_entry_index (rsp_bus.entry_index)
   );

`ifndef SYNTH
   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while a request is in progress");

   // response only posted into an empty or draining output register
   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.slot_free)
      else $error("response posted over a pending response");

   // a new response appears only after a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !$past(rsp_bus.valid)) |-> $past(cmd.commit))
      else $error("response valid without a commit");
`endif

endmodule

// File: hw/rtl/rpct_ctrl.sv
// ----------------------------------------------------------------------------
// rpct_ctrl
// Sequencer: takes a request, runs the prechecks, walks the table and
// posts the response into the output register.
// ----------------------------------------------------------------------------
module rpct_ctrl
   import rpct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  rpct_stat_type stat,
   output rpct_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_START  = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.start   = 1'b0;
      cmd.scan    = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = stat.need_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // wait for the output register to drain
            if (stat.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/rpct_datapath.sv
// ----------------------------------------------------------------------------
// rpct_datapath
// Configuration registers, rectangle memory, prechecks, scan compare and
// the response register.
// ----------------------------------------------------------------------------
module rpct_datapath
   import rpct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  rpct_cmd_type         cmd,
   output rpct_stat_type        stat,
   input  logic                 req_func,
   input  logic [7:0]           req_corner_x,
   input  logic [7:0]           req_corner_y,
   input  logic [7:0]           req_rect_width,
   input  logic [7:0]           req_rect_height,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [3:0]           rsp_status,
   output logic [5:0]           rsp_entry_index
);

   // request held for the whole operation
   logic       func_ff;
   logic [7:0] x_ff, y_ff, w_ff, h_ff;

   logic [7:0] min_width_ff, min_height_ff, field_cols_ff, field_rows_ff;
   logic       rotated_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [31:0]      rd_data_ff;
   logic [31:0]      rect_mem [MAX_RECTS];

   logic [3:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_index_ff, res_index_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_status_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [31:0]      rsp_index_wide;

   logic [3:0] pre_code;
   logic [7:0] lim_x, lim_y;
   logic       x_ok, y_ok;
   logic       issue, hit, last, store;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         x_ff    <= req_corner_x;
         y_ff    <= req_corner_y;
         w_ff    <= req_rect_width;
         h_ff    <= req_rect_height;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff  <= RST_MIN_WIDTH;
         min_height_ff <= RST_MIN_HEIGHT;
         field_cols_ff <= RST_FIELD_COLS;
         field_rows_ff <= RST_FIELD_ROWS;
         rotated_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_WIDTH:  min_width_ff  <= csr_data;
            CSR_MIN_HEIGHT: min_height_ff <= csr_data;
            CSR_FIELD_COLS: field_cols_ff <= csr_data;
            CSR_FIELD_ROWS: field_rows_ff <= csr_data;
            CSR_ROTATED:    rotated_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // prechecks, first failing one wins
   assign lim_x = rotated_ff ? field_rows_ff : field_cols_ff;
   assign lim_y = rotated_ff ? field_cols_ff : field_rows_ff;
   assign x_ok  = (x_ff != 8'd0) && (({1'b0, x_ff} + {1'b0, w_ff}) < ({1'b0, lim_x} + 9'd1));
   assign y_ok  = (y_ff != 8'd0) && (({1'b0, y_ff} + {1'b0, h_ff}) < ({1'b0, lim_y} + 9'd1));

   always_comb begin
      if (func_ff) begin
         pre_code = ST_NOTFOUND;
      end else if (w_ff < min_width_ff) begin
         pre_code = ST_NARROW;
      end else if (h_ff < min_height_ff) begin
         pre_code = ST_SHORT;
      end else if (!x_ok) begin
         pre_code = ST_XOUT;
      end else if (!y_ok) begin
         pre_code = ST_YOUT;
      end else if (count_ff >= CNT_W'(MAX_RECTS)) begin
         pre_code = ST_FULL;
      end else begin
         pre_code = ST_STORED;
      end
   end

   // table walk: one read issued per cycle, compared in the next cycle
   assign issue = cmd.scan && (scan_ptr_ff < count_ff);

   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      if (cmd.start) begin
         scan_ptr_in = '0;
      end else if (issue) begin
         scan_ptr_in = scan_ptr_ff + CNT_W'(1);
      end
   end

   always_comb begin
      if (func_ff) begin
         hit = rd_vld_ff && (rd_data_ff[7:0] == x_ff) && (rd_data_ff[15:8] == y_ff);
      end else begin
         hit = rd_vld_ff
               && spans_overlap(x_ff, w_ff, rd_data_ff[7:0], rd_data_ff[23:16])
               && spans_overlap(y_ff, h_ff, rd_data_ff[15:8], rd_data_ff[31:24]);
      end
   end

   assign last  = rd_vld_ff && ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);
   assign store = cmd.commit && (res_status_ff == ST_STORED);

   assign stat.need_scan = ((func_ff) || (pre_code == ST_STORED)) && (count_ff != '0);
   assign stat.scan_done = hit || last;
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      if (cmd.start) begin
         res_status_in = pre_code;
         res_index_in  = '0;
      end else if (cmd.scan && hit) begin
         res_status_in = func_ff ? ST_FOUND : ST_COLLIDE;
         res_index_in  = func_ff ? rd_idx_ff : '0;
      end
   end

   assign count_in     = store ? (count_ff + CNT_W'(1)) : count_ff;
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ptr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ptr_ff  <= scan_ptr_in;
         rd_vld_ff    <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      if (cmd.commit) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= store ? count_ff[IDX_W-1:0] : res_index_ff;
      end
   end

   // rectangle memory, x y width height one byte each
   always_ff @(posedge clock) begin
      if (store) begin
         rect_mem[count_ff[IDX_W-1:0]] <= {h_ff, w_ff, y_ff, x_ff};
      end
      if (issue) begin
         rd_data_ff <= rect_mem[scan_ptr_ff[IDX_W-1:0]];
         rd_idx_ff  <= scan_ptr_ff[IDX_W-1:0];
      end
   end

   assign rsp_index_wide  = 32'(rsp_index_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_wide[5:0];

endmodule
